// ===== hw/rtl/plsu_pkg.sv =====
// ----------------------------------------------------------------------------
// plsu_pkg
// Shared types and constants of the positional list store unit.
// ----------------------------------------------------------------------------
package plsu_pkg;

  // number of list entries held in the cell chain
  localparam int unsigned CAPACITY = 64;
  localparam int unsigned IdxW     = $clog2(CAPACITY);
  localparam int unsigned CntW     = 7;
  localparam int unsigned DataW    = 32;

  // command kinds
  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_GET    = 2'd2,
    KIND_SET    = 2'd3
  } kind_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

endpackage

// ===== hw/rtl/positional_list_store_unit.sv =====
// ----------------------------------------------------------------------------
// positional_list_store_unit
// Ordered list of signed 32-bit values kept in a chain of shifting cells.
// ----------------------------------------------------------------------------
// Each command beat is held in an input register and executed across all 64
// cells at once: insert moves every cell from the position up by one, remove
// moves every cell above the position down by one, get and set touch one
// cell. The result lands in an output register, so one command completes
// per cycle as long as results are taken; a held result stalls the input
// register, and the input side still takes one more beat while that
// register is empty. Every command returns exactly one result beat with
// status, the entry read by a get (zero otherwise), the entry count and an
// empty flag.
module positional_list_store_unit
  import plsu_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        kind_i,
  input  logic [6:0]        position_i,
  input  logic signed [31:0] value_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        status_o,
  output logic signed [31:0] read_value_o,
  output logic [6:0]        entry_count_o,
  output logic              list_empty_o
);

  // input register
  logic                s1_valid_q;
  kind_e               s1_kind_q;
  logic [CntW-1:0]     s1_pos_q;
  logic [DataW-1:0]    s1_val_q;

  // list state
  logic [DataW-1:0]    entries_q [CAPACITY];
  logic [DataW-1:0]    entries_d [CAPACITY];
  logic [CntW-1:0]     count_q, count_d;

  // result register
  logic                out_valid_q;
  status_e             status_q, status_d;
  logic [DataW-1:0]    read_q, read_d;
  logic [CntW-1:0]     cnt_out_q;
  logic                empty_q;

  logic advance;
  logic pos_below;
  logic pos_le;
  logic full;
  logic do_ins, do_rem, do_set;

  // the held command executes when the result register can take it
  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_kind_q <= kind_e'(kind_i);
      s1_pos_q  <= position_i;
      s1_val_q  <= value_i;
    end
  end

  // range checks and status
  assign pos_below = s1_pos_q < count_q;
  assign pos_le    = s1_pos_q <= count_q;
  assign full      = count_q == CntW'(CAPACITY);

  always_comb begin
    status_d = ST_OK;
    read_d   = '0;
    do_ins   = 1'b0;
    do_rem   = 1'b0;
    do_set   = 1'b0;
    count_d  = count_q;
    unique case (s1_kind_q)
      KIND_INSERT: begin
        if (!pos_le) begin
          status_d = ST_RANGE;
        end else if (full) begin
          status_d = ST_FULL;
        end else begin
          do_ins  = 1'b1;
          count_d = count_q + CntW'(1);
        end
      end
      KIND_REMOVE: begin
        if (count_q == '0) begin
          status_d = ST_EMPTY;
        end else if (!pos_below) begin
          status_d = ST_RANGE;
        end else begin
          do_rem  = 1'b1;
          count_d = count_q - CntW'(1);
        end
      end
      KIND_GET: begin
        if (!pos_below) begin
          status_d = ST_RANGE;
        end else begin
          read_d = entries_q[s1_pos_q[IdxW-1:0]];
        end
      end
      KIND_SET: begin
        if (!pos_below) begin
          status_d = ST_RANGE;
        end else begin
          do_set = 1'b1;
        end
      end
      default: begin
        status_d = ST_RANGE;
      end
    endcase
  end

  // next value of every cell from its own and its neighbors' contents
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      entries_d[i] = entries_q[i];
      if (do_ins) begin
        if (CntW'(i) == s1_pos_q) begin
          entries_d[i] = s1_val_q;
        end else if (i > 0 && CntW'(i) > s1_pos_q) begin
          entries_d[i] = entries_q[(i > 0) ? i - 1 : 0];
        end
      end else if (do_rem) begin
        if (i < CAPACITY - 1 && CntW'(i) >= s1_pos_q) begin
          entries_d[i] = entries_q[(i < CAPACITY - 1) ? i + 1 : i];
        end
      end else if (do_set) begin
        if (CntW'(i) == s1_pos_q) begin
          entries_d[i] = s1_val_q;
        end
      end
    end
  end

  // list state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (advance) begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      for (int i = 0; i < CAPACITY; i++) begin
        entries_q[i] <= entries_d[i];
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      status_q  <= status_d;
      read_q    <= read_d;
      cnt_out_q <= count_d;
      empty_q   <= count_d == '0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign read_value_o  = read_q;
  assign entry_count_o = cnt_out_q;
  assign list_empty_o  = empty_q;

endmodule

// ===== hw/rtl/plsu_checker.sv =====
// ----------------------------------------------------------------------------
// plsu_checker
// Port-level checks of the positional list store unit, bound to the top.
// ----------------------------------------------------------------------------
module plsu_checker
  import plsu_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [1:0]        status_o,
  input logic signed [31:0] read_value_o,
  input logic [6:0]        entry_count_o,
  input logic              list_empty_o
);

  // a stalled result beat holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) &&
    $stable(read_value_o) && $stable(entry_count_o) && $stable(list_empty_o))
    else $error("result beat changed while stalled");

  // input side only stalls behind a held result beat
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled without a held result beat");

  // empty flag agrees with the count
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (list_empty_o == (entry_count_o == '0)))
    else $error("empty flag disagrees with entry count");

  // count never exceeds the capacity
  a_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (entry_count_o <= 7'(CAPACITY)))
    else $error("entry count above capacity");

  // only a good get returns data
  a_read_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> (read_value_o == '0))
    else $error("read value nonzero on a failed command");

endmodule

bind positional_list_store_unit plsu_checker u_plsu_checker (.*);
